// ===== design/rcbp_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rcbp_pkg
// Shared widths, command and status codes of the buffer pool unit.
// ----------------------------------------------------------------------------
package rcbp_pkg;

    localparam int unsigned MAX_FRAMES = 16;
    localparam int unsigned IDX_W      = 4;
    localparam int unsigned SIZE_W     = 5;
    localparam int unsigned REF_W      = 8;
    localparam int unsigned STAT_W     = 32;

    localparam logic [REF_W-1:0]  REF_MAX   = 8'd255;
    localparam logic [SIZE_W-1:0] POOL_RST  = 5'd16;
    localparam logic [SIZE_W-1:0] POOL_MAX  = 5'd16;
    localparam logic [SIZE_W-1:0] POOL_MIN  = 5'd1;

    typedef enum logic [1:0] {
        CMD_ACQUIRE = 2'd0,
        CMD_RELEASE = 2'd1,
        CMD_ADD_REF = 2'd2,
        CMD_UNUSED  = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        ST_OK          = 3'd0,
        ST_STILL_REF   = 3'd1,
        ST_POOL_EMPTY  = 3'd2,
        ST_DOUBLE_REL  = 3'd3,
        ST_BAD_INDEX   = 3'd4
    } t_status;

endpackage
`default_nettype wire

// ===== design/rcbp_stack_mem.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rcbp_stack_mem
// Free-index stack storage: one write and one registered read per cycle.
// An entry not written since the last clear reads as its own index.
// ----------------------------------------------------------------------------
module rcbp_stack_mem (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_clr,
    input  wire logic                       i_rd_en,
    input  wire logic [rcbp_pkg::IDX_W-1:0] i_rd_addr,
    output logic      [rcbp_pkg::IDX_W-1:0] o_rd_data,
    input  wire logic                       i_wr_en,
    input  wire logic [rcbp_pkg::IDX_W-1:0] i_wr_addr,
    input  wire logic [rcbp_pkg::IDX_W-1:0] i_wr_data
);

    logic [rcbp_pkg::IDX_W-1:0]    r_mem [rcbp_pkg::MAX_FRAMES];
    logic [rcbp_pkg::MAX_FRAMES-1:0] r_vld;
    logic [rcbp_pkg::IDX_W-1:0]    r_rd_data;
    logic [rcbp_pkg::IDX_W-1:0]    r_rd_addr;
    logic                          r_rd_vld;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
            r_rd_addr <= i_rd_addr;
            r_rd_vld  <= r_vld[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clr) begin
            r_vld <= '0;
        end else if (i_wr_en) begin
            r_vld[i_wr_addr] <= 1'b1;
        end
    end

    assign o_rd_data = r_rd_vld ? r_rd_data : r_rd_addr;

endmodule
`default_nettype wire

// ===== design/rcbp_ref_mem.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rcbp_ref_mem
// Reference count storage: one write and one registered read per cycle.
// An entry not written since the last clear reads as zero.
// ----------------------------------------------------------------------------
module rcbp_ref_mem (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_clr,
    input  wire logic                       i_rd_en,
    input  wire logic [rcbp_pkg::IDX_W-1:0] i_rd_addr,
    output logic      [rcbp_pkg::REF_W-1:0] o_rd_data,
    input  wire logic                       i_wr_en,
    input  wire logic [rcbp_pkg::IDX_W-1:0] i_wr_addr,
    input  wire logic [rcbp_pkg::REF_W-1:0] i_wr_data
);

    logic [rcbp_pkg::REF_W-1:0]      r_mem [rcbp_pkg::MAX_FRAMES];
    logic [rcbp_pkg::MAX_FRAMES-1:0] r_vld;
    logic [rcbp_pkg::REF_W-1:0]      r_rd_data;
    logic                            r_rd_vld;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
            r_rd_vld  <= r_vld[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clr) begin
            r_vld <= '0;
        end else if (i_wr_en) begin
            r_vld[i_wr_addr] <= 1'b1;
        end
    end

    assign o_rd_data = r_rd_vld ? r_rd_data : '0;

endmodule
`default_nettype wire

// ===== design/refcounted_buffer_pool_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// refcounted_buffer_pool_unit
// Reference-counted frame buffer pool with a LIFO free stack and statistics.
// ----------------------------------------------------------------------------
// In the accept cycle of a command the free stack and the reference count
// memory are read (synchronous read); in the execute state the command is
// resolved, both memories are written back and the result word is loaded
// into the output register. A new command is taken only once the previous
// one is resolved; a result that is not taken holds the following command
// in its execute state. Writing pool_size reinitializes the pool and may be
// done only while idle.
// ----------------------------------------------------------------------------
module refcounted_buffer_pool_unit (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // configuration
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [4:0]  i_cfg_pool_size,
    // command channel
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [1:0]  i_cmd,
    input  wire logic [3:0]  i_frame_index,
    // result channel
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [2:0]       o_status,
    output logic [3:0]       o_granted_index,
    output logic [7:0]       o_ref_after,
    output logic [4:0]       o_free_count,
    output logic [4:0]       o_in_use,
    output logic [4:0]       o_peak_in_use,
    output logic [31:0]      o_acquire_total,
    output logic [31:0]      o_release_total,
    output logic [31:0]      o_wait_total,
    output logic [31:0]      o_timeout_total
);

    localparam int unsigned IW = rcbp_pkg::IDX_W;
    localparam int unsigned SW = rcbp_pkg::SIZE_W;
    localparam int unsigned RW = rcbp_pkg::REF_W;
    localparam int unsigned CW = rcbp_pkg::STAT_W;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } t_state;

    t_state r_state, n_state;

    logic [SW-1:0] r_pool, r_depth, n_depth, r_peak, n_peak;
    logic [CW-1:0] r_acq_cnt, r_rel_cnt, r_wait_cnt;
    logic          n_acq_inc, n_rel_inc, n_wait_inc;

    logic [1:0]    r_cmd;
    logic [IW-1:0] r_idx;

    logic          r_out_vld;
    logic [2:0]    r_status, n_status;
    logic [IW-1:0] r_granted, n_granted;
    logic [RW-1:0] r_ref_after, n_ref_after;

    logic          cfg_wr, in_acc, exec_go;
    logic [SW-1:0] cfg_size;

    logic [IW-1:0] stk_rd_data, stk_wr_addr, stk_wr_data;
    logic          stk_wr_en;
    logic [RW-1:0] ref_rd_data, ref_wr_data;
    logic [IW-1:0] ref_wr_addr;
    logic          ref_wr_en;

    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid;
    assign o_ready     = (r_state == S_IDLE);
    assign in_acc      = i_valid && o_ready;
    assign exec_go     = (r_state == S_EXEC) && (!r_out_vld || i_ready);

    always_comb begin
        if (i_cfg_pool_size < rcbp_pkg::POOL_MIN) begin
            cfg_size = rcbp_pkg::POOL_MIN;
        end else if (i_cfg_pool_size > rcbp_pkg::POOL_MAX) begin
            cfg_size = rcbp_pkg::POOL_MAX;
        end else begin
            cfg_size = i_cfg_pool_size;
        end
    end

    rcbp_stack_mem u_stack (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_clr     (cfg_wr),
        .i_rd_en   (in_acc),
        .i_rd_addr (IW'(r_depth - SW'(1))),
        .o_rd_data (stk_rd_data),
        .i_wr_en   (stk_wr_en),
        .i_wr_addr (stk_wr_addr),
        .i_wr_data (stk_wr_data)
    );

    rcbp_ref_mem u_refs (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_clr     (cfg_wr),
        .i_rd_en   (in_acc),
        .i_rd_addr (i_frame_index),
        .o_rd_data (ref_rd_data),
        .i_wr_en   (ref_wr_en),
        .i_wr_addr (ref_wr_addr),
        .i_wr_data (ref_wr_data)
    );

    // resolve the command held in r_cmd / r_idx against the read data
    always_comb begin
        logic [SW-1:0] used;
        used        = '0;
        n_depth     = r_depth;
        n_peak      = r_peak;
        n_acq_inc   = 1'b0;
        n_rel_inc   = 1'b0;
        n_wait_inc  = 1'b0;
        n_status    = rcbp_pkg::ST_OK;
        n_granted   = r_idx;
        n_ref_after = '0;
        stk_wr_en   = 1'b0;
        stk_wr_addr = r_depth[IW-1:0];
        stk_wr_data = r_idx;
        ref_wr_en   = 1'b0;
        ref_wr_addr = r_idx;
        ref_wr_data = '0;
        case (r_cmd)
            rcbp_pkg::CMD_ACQUIRE: begin
                if (r_depth == '0) begin
                    n_status   = rcbp_pkg::ST_POOL_EMPTY;
                    n_wait_inc = 1'b1;
                end else begin
                    n_depth     = r_depth - SW'(1);
                    n_granted   = stk_rd_data;
                    n_ref_after = RW'(1);
                    ref_wr_en   = 1'b1;
                    ref_wr_addr = stk_rd_data;
                    ref_wr_data = RW'(1);
                    n_acq_inc   = 1'b1;
                    used        = r_pool - n_depth;
                    if (used > r_peak) begin
                        n_peak = used;
                    end
                end
            end
            rcbp_pkg::CMD_RELEASE, rcbp_pkg::CMD_ADD_REF: begin
                if ({1'b0, r_idx} >= r_pool) begin
                    n_status = rcbp_pkg::ST_BAD_INDEX;
                end else if (r_cmd == rcbp_pkg::CMD_ADD_REF) begin
                    if (ref_rd_data < rcbp_pkg::REF_MAX) begin
                        ref_wr_data = ref_rd_data + RW'(1);
                    end else begin
                        ref_wr_data = ref_rd_data;
                    end
                    ref_wr_en   = 1'b1;
                    n_ref_after = ref_wr_data;
                end else if (ref_rd_data == '0) begin
                    n_status = rcbp_pkg::ST_DOUBLE_REL;
                end else if (ref_rd_data > RW'(1)) begin
                    ref_wr_data = ref_rd_data - RW'(1);
                    ref_wr_en   = 1'b1;
                    n_ref_after = ref_wr_data;
                    n_status    = rcbp_pkg::ST_STILL_REF;
                end else begin
                    ref_wr_en = 1'b1;
                    // push back unless the stack is already full
                    if (r_depth < r_pool) begin
                        stk_wr_en = 1'b1;
                        n_depth   = r_depth + SW'(1);
                        n_rel_inc = 1'b1;
                    end
                end
            end
            default: begin
                n_status = rcbp_pkg::ST_BAD_INDEX;
            end
        endcase
        if (!exec_go) begin
            stk_wr_en = 1'b0;
            ref_wr_en = 1'b0;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (exec_go) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_out_vld  <= 1'b0;
            r_pool     <= rcbp_pkg::POOL_RST;
            r_depth    <= rcbp_pkg::POOL_RST;
            r_peak     <= '0;
            r_acq_cnt  <= '0;
            r_rel_cnt  <= '0;
            r_wait_cnt <= '0;
        end else if (cfg_wr) begin
            r_state    <= S_IDLE;
            r_pool     <= cfg_size;
            r_depth    <= cfg_size;
            r_peak     <= '0;
            r_acq_cnt  <= '0;
            r_rel_cnt  <= '0;
            r_wait_cnt <= '0;
        end else begin
            r_state <= n_state;
            if (exec_go) begin
                r_out_vld  <= 1'b1;
                r_depth    <= n_depth;
                r_peak     <= n_peak;
                r_acq_cnt  <= r_acq_cnt + CW'(n_acq_inc);
                r_rel_cnt  <= r_rel_cnt + CW'(n_rel_inc);
                r_wait_cnt <= r_wait_cnt + CW'(n_wait_inc);
            end else if (i_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // hold the command and the result word
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_cmd <= i_cmd;
            r_idx <= i_frame_index;
        end
        if (exec_go) begin
            r_status    <= n_status;
            r_granted   <= n_granted;
            r_ref_after <= n_ref_after;
        end
    end

    // statistics change only when a result word is loaded, a pool size is written or on reset
    assign o_valid         = r_out_vld;
    assign o_status        = r_status;
    assign o_granted_index = r_granted;
    assign o_ref_after     = r_ref_after;
    assign o_free_count    = r_depth;
    assign o_in_use        = r_pool - r_depth;
    assign o_peak_in_use   = r_peak;
    assign o_acquire_total = r_acq_cnt;
    assign o_release_total = r_rel_cnt;
    assign o_wait_total    = r_wait_cnt;
    assign o_timeout_total = r_wait_cnt;

endmodule
`default_nettype wire

// ===== tb/sv/pool_result_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pool_result_checker
// Watches the configuration, command and result channels of the buffer pool,
// keeps its own copy of the pool state, predicts one result word per accepted
// command and compares every accepted result with the oldest prediction.
// ----------------------------------------------------------------------------
module pool_result_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    input  logic        o_cfg_ready,
    input  logic [4:0]  i_cfg_pool_size,
    input  logic        i_valid,
    input  logic        o_ready,
    input  logic [1:0]  i_cmd,
    input  logic [3:0]  i_frame_index,
    input  logic        o_valid,
    input  logic        i_ready,
    input  logic [2:0]  o_status,
    input  logic [3:0]  o_granted_index,
    input  logic [7:0]  o_ref_after,
    input  logic [4:0]  o_free_count,
    input  logic [4:0]  o_in_use,
    input  logic [4:0]  o_peak_in_use,
    input  logic [31:0] o_acquire_total,
    input  logic [31:0] o_release_total,
    input  logic [31:0] o_wait_total,
    input  logic [31:0] o_timeout_total,
    output int          pending_count,
    output int          mismatch_count,
    output int          checked_count
);

    localparam int unsigned SIZE_W = rcbp_pkg::SIZE_W;
    localparam int unsigned IDX_W  = rcbp_pkg::IDX_W;
    localparam int unsigned REF_W  = rcbp_pkg::REF_W;
    localparam int unsigned FRAMES = rcbp_pkg::MAX_FRAMES;
    localparam int          SLOTS  = 64;

    typedef struct packed {
        rcbp_pkg::t_status status;
        logic [3:0]        granted;
        logic [7:0]        ref_after;
        logic [4:0]        free_count;
        logic [4:0]        in_use;
        logic [4:0]        peak;
        logic [31:0]       acquires;
        logic [31:0]       releases;
        logic [31:0]       waits;
        logic [31:0]       timeouts;
    } t_pool_result;

    // mirrored pool state
    logic [SIZE_W-1:0] pool_size;
    logic [SIZE_W-1:0] stack_depth;
    logic [IDX_W-1:0]  free_stack [FRAMES];
    logic [REF_W-1:0]  ref_mirror [FRAMES];
    logic [SIZE_W-1:0] peak_used;
    logic [31:0]       acquire_cnt;
    logic [31:0]       release_cnt;
    logic [31:0]       wait_cnt;
    logic [31:0]       timeout_cnt;

    // ring of predicted words, oldest at rd_ptr
    t_pool_result expected_words [SLOTS];
    int           wr_ptr = 0;
    int           rd_ptr = 0;
    int           errors = 0;
    int           checked = 0;

    assign mismatch_count = errors;
    assign checked_count  = checked;

    task automatic reload_pool(input logic [SIZE_W-1:0] size);
        if (size < rcbp_pkg::POOL_MIN) begin
            pool_size = rcbp_pkg::POOL_MIN;
        end else if (size > rcbp_pkg::POOL_MAX) begin
            pool_size = rcbp_pkg::POOL_MAX;
        end else begin
            pool_size = size;
        end
        for (int i = 0; i < FRAMES; i++) begin
            free_stack[i] = IDX_W'(i);
            ref_mirror[i] = '0;
        end
        stack_depth = pool_size;
        peak_used   = '0;
        acquire_cnt = '0;
        release_cnt = '0;
        wait_cnt    = '0;
        timeout_cnt = '0;
    endtask

    function automatic t_pool_result execute_command(input rcbp_pkg::t_cmd cmd,
                                                     input logic [IDX_W-1:0] idx);
        t_pool_result      r;
        logic [IDX_W-1:0]  b;
        logic [SIZE_W-1:0] used;
        r = '0;
        r.status    = rcbp_pkg::ST_OK;
        r.granted   = idx;
        r.ref_after = '0;
        case (cmd)
            rcbp_pkg::CMD_ACQUIRE: begin
                if (stack_depth == 0) begin
                    r.status = rcbp_pkg::ST_POOL_EMPTY;
                    wait_cnt++;
                    timeout_cnt++;
                end else begin
                    stack_depth = stack_depth - 1'b1;
                    b = free_stack[stack_depth[IDX_W-1:0]];
                    ref_mirror[b] = 8'd1;
                    r.granted     = b;
                    r.ref_after   = 8'd1;
                    acquire_cnt++;
                    used = pool_size - stack_depth;
                    if (used > peak_used) peak_used = used;
                end
            end
            rcbp_pkg::CMD_RELEASE, rcbp_pkg::CMD_ADD_REF: begin
                if ({1'b0, idx} >= pool_size) begin
                    r.status = rcbp_pkg::ST_BAD_INDEX;
                end else begin
                    if (cmd == rcbp_pkg::CMD_ADD_REF) begin
                        // saturate at the top of the count range
                        if (ref_mirror[idx] < rcbp_pkg::REF_MAX) ref_mirror[idx]++;
                    end else if (ref_mirror[idx] == 0) begin
                        r.status = rcbp_pkg::ST_DOUBLE_REL;
                    end else if (ref_mirror[idx] > 1) begin
                        ref_mirror[idx]--;
                        r.status = rcbp_pkg::ST_STILL_REF;
                    end else begin
                        ref_mirror[idx] = '0;
                        // drop the push when the stack is already full
                        if (stack_depth < pool_size) begin
                            free_stack[stack_depth[IDX_W-1:0]] = idx;
                            stack_depth = stack_depth + 1'b1;
                            release_cnt++;
                        end
                    end
                    r.ref_after = ref_mirror[idx];
                end
            end
            default: r.status = rcbp_pkg::ST_BAD_INDEX;
        endcase
        r.free_count = stack_depth;
        r.in_use     = pool_size - stack_depth;
        r.peak       = peak_used;
        r.acquires   = acquire_cnt;
        r.releases   = release_cnt;
        r.waits      = wait_cnt;
        r.timeouts   = timeout_cnt;
        return r;
    endfunction

    function automatic int field_diff(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            return 1;
        end
        return 0;
    endfunction

    always @(posedge i_clk) begin
        t_pool_result want;
        if (!i_rst_n) begin
            reload_pool(rcbp_pkg::POOL_RST);
            wr_ptr = 0;
            rd_ptr = 0;
        end else begin
            // pop before push: a result never belongs to the word taken this edge
            if (o_valid && i_ready) begin
                if (wr_ptr == rd_ptr) begin
                    $error("result word with no command waiting");
                    errors++;
                end else begin
                    want = expected_words[rd_ptr % SLOTS];
                    rd_ptr++;
                    checked++;
                    errors += field_diff("status", want.status, o_status);
                    errors += field_diff("granted_index", want.granted, o_granted_index);
                    errors += field_diff("ref_after", want.ref_after, o_ref_after);
                    errors += field_diff("free_count", want.free_count, o_free_count);
                    errors += field_diff("in_use", want.in_use, o_in_use);
                    errors += field_diff("peak_in_use", want.peak, o_peak_in_use);
                    errors += field_diff("acquire_total", want.acquires, o_acquire_total);
                    errors += field_diff("release_total", want.releases, o_release_total);
                    errors += field_diff("wait_total", want.waits, o_wait_total);
                    errors += field_diff("timeout_total", want.timeouts, o_timeout_total);
                end
            end
            if (i_cfg_valid && o_cfg_ready) reload_pool(i_cfg_pool_size);
            if (i_valid && o_ready) begin
                if (wr_ptr - rd_ptr >= SLOTS) begin
                    $error("too many commands waiting for results");
                    errors++;
                end else begin
                    expected_words[wr_ptr % SLOTS] =
                        execute_command(rcbp_pkg::t_cmd'(i_cmd), i_frame_index);
                    wr_ptr++;
                end
            end
        end
        pending_count <= wr_ptr - rd_ptr;
    end

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus for the reference-counted buffer pool: directed corner commands,
// then random command streams over several pool sizes and pacing modes.
// ----------------------------------------------------------------------------
module tb;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [4:0]  i_cfg_pool_size;
    logic        i_valid;
    logic        o_ready;
    logic [1:0]  i_cmd;
    logic [3:0]  i_frame_index;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [2:0]  o_status;
    logic [3:0]  o_granted_index;
    logic [7:0]  o_ref_after;
    logic [4:0]  o_free_count;
    logic [4:0]  o_in_use;
    logic [4:0]  o_peak_in_use;
    logic [31:0] o_acquire_total;
    logic [31:0] o_release_total;
    logic [31:0] o_wait_total;
    logic [31:0] o_timeout_total;

    int pending_count;
    int mismatch_count;
    int checked_count;
    int sender_idle_pct = 0;
    int ready_stall_pct = 0;
    int active_size = 16;
    int commands_sent = 0;

    refcounted_buffer_pool_unit dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_pool_size (i_cfg_pool_size),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_cmd           (i_cmd),
        .i_frame_index   (i_frame_index),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_status        (o_status),
        .o_granted_index (o_granted_index),
        .o_ref_after     (o_ref_after),
        .o_free_count    (o_free_count),
        .o_in_use        (o_in_use),
        .o_peak_in_use   (o_peak_in_use),
        .o_acquire_total (o_acquire_total),
        .o_release_total (o_release_total),
        .o_wait_total    (o_wait_total),
        .o_timeout_total (o_timeout_total)
    );

    pool_result_checker result_check (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_pool_size (i_cfg_pool_size),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_cmd           (i_cmd),
        .i_frame_index   (i_frame_index),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_status        (o_status),
        .o_granted_index (o_granted_index),
        .o_ref_after     (o_ref_after),
        .o_free_count    (o_free_count),
        .o_in_use        (o_in_use),
        .o_peak_in_use   (o_peak_in_use),
        .o_acquire_total (o_acquire_total),
        .o_release_total (o_release_total),
        .o_wait_total    (o_wait_total),
        .o_timeout_total (o_timeout_total),
        .pending_count   (pending_count),
        .mismatch_count  (mismatch_count),
        .checked_count   (checked_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("FAILURE");
        $finish;
    end

    // result side back-pressure
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(99) >= ready_stall_pct);
        end
    end

    task automatic send_command(input rcbp_pkg::t_cmd cmd, input logic [3:0] idx);
        if ($urandom_range(99) < sender_idle_pct) begin
            i_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < sender_idle_pct);
        end
        i_valid       <= 1'b1;
        i_cmd         <= cmd;
        i_frame_index <= idx;
        do @(posedge i_clk); while (!o_ready);
        commands_sent++;
    endtask

    // hold off new words until every predicted result has been taken
    task automatic drain_results();
        int guard;
        guard = 0;
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_count != 0 && guard < 20000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_pool_size(input logic [4:0] size);
        drain_results();
        i_cfg_valid     <= 1'b1;
        i_cfg_pool_size <= size;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (size == 0) active_size = 1;
        else if (size > rcbp_pkg::POOL_MAX) active_size = rcbp_pkg::POOL_MAX;
        else active_size = size;
    endtask

    function automatic logic [3:0] pick_frame();
        return 4'($urandom_range(active_size - 1));
    endfunction

    task automatic random_commands(input int count);
        int pick;
        for (int n = 0; n < count; n++) begin
            if (n == count / 2) drain_results();
            pick = $urandom_range(99);
            if (pick < 32) begin
                send_command(rcbp_pkg::CMD_ACQUIRE, 4'($urandom_range(15)));
            end else if (pick < 64) begin
                send_command(rcbp_pkg::CMD_RELEASE, pick_frame());
            end else if (pick < 86) begin
                send_command(rcbp_pkg::CMD_ADD_REF, pick_frame());
            end else if (pick < 95) begin
                // indices anywhere, mostly outside small pools
                send_command($urandom_range(1) ? rcbp_pkg::CMD_RELEASE
                                               : rcbp_pkg::CMD_ADD_REF,
                             4'($urandom_range(15)));
            end else begin
                send_command(rcbp_pkg::CMD_UNUSED, 4'($urandom_range(15)));
            end
        end
    endtask

    initial begin
        logic [3:0] hot;
        i_rst_n         = 1'b0;
        i_cfg_valid     = 1'b0;
        i_cfg_pool_size = '0;
        i_valid         = 1'b0;
        i_cmd           = rcbp_pkg::CMD_ACQUIRE;
        i_frame_index   = '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed, full pool after reset
        send_command(rcbp_pkg::CMD_ADD_REF, 4'd3);
        send_command(rcbp_pkg::CMD_RELEASE, 4'd3);
        send_command(rcbp_pkg::CMD_RELEASE, 4'd3);
        send_command(rcbp_pkg::CMD_UNUSED, 4'd9);
        send_command(rcbp_pkg::CMD_ACQUIRE, 4'd6);
        send_command(rcbp_pkg::CMD_ADD_REF, 4'd15);
        send_command(rcbp_pkg::CMD_RELEASE, 4'd15);
        send_command(rcbp_pkg::CMD_RELEASE, 4'd15);
        send_command(rcbp_pkg::CMD_ADD_REF, 4'd0);

        // directed, single buffer pool
        write_pool_size(5'd1);
        send_command(rcbp_pkg::CMD_ACQUIRE, 4'd7);
        send_command(rcbp_pkg::CMD_ACQUIRE, 4'd10);
        send_command(rcbp_pkg::CMD_RELEASE, 4'd15);
        send_command(rcbp_pkg::CMD_ADD_REF, 4'd1);
        send_command(rcbp_pkg::CMD_ADD_REF, 4'd0);
        send_command(rcbp_pkg::CMD_RELEASE, 4'd0);
        send_command(rcbp_pkg::CMD_RELEASE, 4'd0);
        send_command(rcbp_pkg::CMD_RELEASE, 4'd0);
        send_command(rcbp_pkg::CMD_UNUSED, 4'd0);
        send_command(rcbp_pkg::CMD_ACQUIRE, 4'd5);

        // zero clamps to one buffer
        write_pool_size(5'd0);
        random_commands(120);

        // oversize clamps to the full pool; drive one count into saturation
        write_pool_size(5'd31);
        sender_idle_pct = 50;
        hot = 4'($urandom_range(15));
        send_command(rcbp_pkg::CMD_ACQUIRE, 4'd0);
        for (int n = 0; n < 258; n++) send_command(rcbp_pkg::CMD_ADD_REF, hot);
        random_commands(150);

        write_pool_size(5'($urandom_range(8, 2)));
        sender_idle_pct = 0;
        ready_stall_pct = 50;
        random_commands(165);

        write_pool_size(5'd17);
        sender_idle_pct = 10;
        ready_stall_pct = 10;
        random_commands(165);

        write_pool_size(5'($urandom_range(15, 9)));
        sender_idle_pct = 0;
        ready_stall_pct = 0;
        random_commands(100);

        drain_results();
        if (pending_count != 0) $error("%0d results never arrived", pending_count);

        $display("Sent %0d commands and checked %0d results over pool sizes 1 to 16,",
                 commands_sent, checked_count);
        $display("with clamped size writes, empty pool, saturation and double release.");
        if (mismatch_count == 0 && pending_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
design/rcbp_pkg.sv
design/rcbp_stack_mem.sv
design/rcbp_ref_mem.sv
design/refcounted_buffer_pool_unit.sv
tb/sv/pool_result_checker.sv
tb/sv/tb.sv
